// File: src/swap_slot_bitmap_allocator_assert.svh
// Assertion helpers used by the allocator RTL.
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBMA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBMA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must never be seen.
`define SBMA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// File: src/sbma_pkg.sv
`default_nettype none

package sbma_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = 6;

   // Request actions
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_GRANTED = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_FREED   = 2'd2;
   localparam logic [1:0] STATUS_UNUSED  = 2'd3;

   typedef struct packed {
      logic        action;
      logic [4:0]  request_count;
      logic [11:0] slot_to_release;
   } sbma_req_type;

   typedef struct packed {
      logic [11:0] slot_number;
      logic [1:0]  status;
      logic        last_of_run;
      logic [11:0] slots_free;
   } sbma_rsp_type;

   // What the bit unit reports about one bitmap word
   typedef struct packed {
      logic             full;
      logic [BIT_W-1:0] low_clear;
      logic             bit_set;
      logic [63:0]      grant_word;
      logic [63:0]      release_word;
   } sbma_bit_info_type;

endpackage

`default_nettype wire

// File: src/sbma_bitmap_ram.sv
`default_nettype none

module sbma_bitmap_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [63:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [63:0]            rd_data
);
   import sbma_pkg::*;

   logic [WORD_BITS-1:0] words_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= words_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/sbma_bit_unit.sv
`default_nettype none

module sbma_bit_unit (
   input  wire logic [63:0]               word,
   input  wire logic [5:0]                bit_idx,
   output sbma_pkg::sbma_bit_info_type    info
);
   import sbma_pkg::*;

   logic [BIT_W-1:0] low_idx;

   // Lowest clear bit; 63 when the word is full
   always_comb begin
      low_idx = 6'd63;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            low_idx = BIT_W'(i);
         end
      end
   end

   always_comb begin
      info.full         = &word;
      info.low_clear    = low_idx;
      info.bit_set      = word[bit_idx];
      info.grant_word   = word | (64'd1 << low_idx);
      info.release_word = word & ~(64'd1 << bit_idx);
   end

endmodule

`default_nettype wire

// File: src/swap_slot_bitmap_allocator.sv
// Channel   Ports                       Handshake
// request   start, busy, req            taken when start is high and busy is low
// result    rsp_strobe, rsp             one cycle per result, no back pressure
//
// After reset the bitmap is cleared word by word, with busy high until the last word is written.
// Free: word read, then check and write back.
// Refused allocate: answered from idle. Allocate of N slots: N grants, with full words skipped
// on the way; the shared bit unit handles one word per cycle off the bitmap read port.
// Results leave through an output register; the receiver cannot stall.
`default_nettype none

module swap_slot_bitmap_allocator #(
   parameter int BITMAP_WORDS = 64,
   parameter int MAX_REQUEST  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire sbma_pkg::sbma_req_type req,
   output logic                       rsp_strobe,
   output sbma_pkg::sbma_rsp_type     rsp
);
   import sbma_pkg::*;

   `include "swap_slot_bitmap_allocator_assert.svh"

   localparam int WORD_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int TOTAL_SLOTS = BITMAP_WORDS * WORD_BITS;
   localparam int COUNT_W     = $clog2(TOTAL_SLOTS + 1);
   localparam int SCAN_W      = $clog2(BITMAP_WORDS + 1);
   localparam int EXT_W       = (WORD_W + BIT_W > 12) ? WORD_W + BIT_W : 12;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_FREE  = 4'b0100,
      S_SCAN  = 4'b1000
   } sbma_state_type;

   sbma_state_type    state_ff, state_in;
   logic [WORD_W-1:0] clr_idx_ff, clr_idx_in;
   logic [WORD_W-1:0] search_ff, search_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [4:0]        remain_ff, remain_in;
   logic [SCAN_W-1:0] scanned_ff, scanned_in;
   logic              granted_ff, granted_in;
   logic              use_fwd_ff, use_fwd_in;
   logic [63:0]       fwd_word_ff, fwd_word_in;
   sbma_req_type      req_ff, req_in;
   sbma_rsp_type      rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic              accept;
   logic [EXT_W-1:0]  in_rel_ext, held_rel_ext;
   logic [WORD_W-1:0] in_rel_word, held_rel_word;
   logic              held_rel_ok;
   logic [WORD_W-1:0] search_next;
   logic              alloc_refuse;
   logic              lap_done;
   logic [EXT_W-1:0]  grant_slot;

   logic              wr_en;
   logic [WORD_W-1:0] wr_addr, rd_addr;
   logic [63:0]       wr_data, rd_data, unit_word;
   sbma_bit_info_type info;

   assign accept = start && (state_ff == S_IDLE);

   // Slot number decode for the incoming and the held free request
   assign in_rel_ext    = EXT_W'(req.slot_to_release);
   assign in_rel_word   = in_rel_ext[BIT_W +: WORD_W];
   assign held_rel_ext  = EXT_W'(req_ff.slot_to_release);
   assign held_rel_word = held_rel_ext[BIT_W +: WORD_W];
   assign held_rel_ok   = (req_ff.slot_to_release != 12'd0)
                       && (32'(req_ff.slot_to_release) < TOTAL_SLOTS);

   assign search_next = (search_ff == WORD_W'(BITMAP_WORDS - 1)) ? '0
                                                                 : search_ff + 1'b1;

   assign alloc_refuse = (req.request_count == 5'd0)
                      || (32'(req.request_count) > MAX_REQUEST)
                      || (free_ff < COUNT_W'(req.request_count));

   assign lap_done   = (scanned_ff == SCAN_W'(BITMAP_WORDS));
   assign grant_slot = EXT_W'({search_ff, info.low_clear});

   // Word fed to the bit unit: just-granted word forwarded, else the read data
   assign unit_word = use_fwd_ff ? fwd_word_ff : rd_data;

   sbma_bit_unit u_bit_unit (
      .word    (unit_word),
      .bit_idx (req_ff.slot_to_release[BIT_W-1:0]),
      .info    (info)
   );

   sbma_bitmap_ram #(
      .DEPTH  (BITMAP_WORDS),
      .ADDR_W (WORD_W)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read address: in idle the word the request will use; in scan, look one word ahead of the sequencer
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = (req.action == ACTION_FREE) ? in_rel_word : search_ff;
         S_SCAN:  rd_addr = search_next;
         default: rd_addr = search_ff;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      search_in     = search_ff;
      free_in       = free_ff;
      remain_in     = remain_ff;
      scanned_in    = scanned_ff;
      granted_in    = granted_ff;
      use_fwd_in    = use_fwd_ff;
      fwd_word_in   = fwd_word_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = search_ff;
      wr_data       = info.grant_word;

      case (state_ff)
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_data    = (clr_idx_ff == '0) ? 64'd1 : 64'd0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == WORD_W'(BITMAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               req_in     = req;
               use_fwd_in = 1'b0;
               if (req.action == ACTION_FREE) begin
                  state_in = S_FREE;
               end else if (alloc_refuse) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_in.slot_number = 12'd0;
                  rsp_in.status      = STATUS_REFUSED;
                  rsp_in.last_of_run = 1'b1;
                  rsp_in.slots_free  = 12'(free_ff);
               end else begin
                  remain_in  = req.request_count;
                  scanned_in = '0;
                  granted_in = 1'b0;
                  state_in   = S_SCAN;
               end
            end
         end

         S_FREE: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.slot_number = req_ff.slot_to_release;
            rsp_in.last_of_run = 1'b1;
            if (held_rel_ok && info.bit_set) begin
               wr_en             = 1'b1;
               wr_addr           = held_rel_word;
               wr_data           = info.release_word;
               free_in           = free_ff + 1'b1;
               rsp_in.status     = STATUS_FREED;
               rsp_in.slots_free = 12'(free_ff + 1'b1);
            end else begin
               rsp_in.status     = STATUS_UNUSED;
               rsp_in.slots_free = 12'(free_ff);
            end
            state_in = S_IDLE;
         end

         S_SCAN: begin
            if (info.full) begin
               if (lap_done) begin
                  // No clear bit in a whole lap
                  state_in = S_IDLE;
                  if (!granted_ff) begin
                     rsp_strobe_in      = 1'b1;
                     rsp_in.slot_number = 12'd0;
                     rsp_in.status      = STATUS_REFUSED;
                     rsp_in.last_of_run = 1'b1;
                     rsp_in.slots_free  = 12'(free_ff);
                  end
               end else begin
                  search_in  = search_next;
                  scanned_in = scanned_ff + 1'b1;
                  use_fwd_in = 1'b0;
               end
            end else begin
               // Grant the lowest clear bit of this word
               wr_en              = 1'b1;
               wr_addr            = search_ff;
               wr_data            = info.grant_word;
               fwd_word_in        = info.grant_word;
               use_fwd_in         = 1'b1;
               free_in            = free_ff - 1'b1;
               remain_in          = remain_ff - 1'b1;
               scanned_in         = '0;
               granted_in         = 1'b1;
               rsp_strobe_in      = 1'b1;
               rsp_in.slot_number = grant_slot[11:0];
               rsp_in.status      = STATUS_GRANTED;
               rsp_in.last_of_run = (remain_ff == 5'd1);
               rsp_in.slots_free  = 12'(free_ff - 1'b1);
               if (remain_ff == 5'd1) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         search_ff     <= '0;
         free_ff       <= COUNT_W'(TOTAL_SLOTS - 1);
         remain_ff     <= '0;
         scanned_ff    <= '0;
         granted_ff    <= 1'b0;
         use_fwd_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         search_ff     <= search_in;
         free_ff       <= free_in;
         remain_ff     <= remain_in;
         scanned_ff    <= scanned_in;
         granted_ff    <= granted_in;
         use_fwd_ff    <= use_fwd_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_word_ff <= fwd_word_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `SBMA_ASSERT_NEVER(a_no_lap_exhaust, clock, reset,
      (state_ff == S_SCAN) && info.full && lap_done,
      "bitmap scan found no clear bit despite free count")
   `SBMA_ASSERT_IMP(a_free_step, clock, reset, !$past(reset),
      (free_ff == $past(free_ff)) || (free_ff == $past(free_ff) + 1'b1)
         || (free_ff == $past(free_ff) - 1'b1),
      "free count moved by more than one")
   `SBMA_ASSERT_IMP(a_last_ends_scan, clock, reset,
      rsp_strobe_ff && rsp_ff.last_of_run, state_ff != S_SCAN,
      "scan still running after last result")
   `SBMA_ASSERT_NXT(a_accept_reacts, clock, reset, start && !busy,
      busy || rsp_strobe, "accepted request neither busy nor answered")

endmodule

`default_nettype wire

// File: bench/swap_slot_bitmap_allocator_tb.sv
`timescale 1ns / 100ps

module swap_slot_bitmap_allocator_tb;
   import sbma_pkg::*;

   localparam int NUM_WORDS     = 64;
   localparam int MAX_COUNT     = 16;
   localparam int TOTAL_SLOTS   = NUM_WORDS * WORD_BITS;
   localparam int RANDOM_ITEMS  = 95;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_PRINTED   = 40;

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   sbma_req_type req_bus = '0;
   logic         rsp_strobe;
   sbma_rsp_type rsp;

   // Requests waiting for the driver; a set drain flag holds the request back
   // until every expected result has come
   sbma_req_type pending_reqs[$];
   bit           pending_drain[$];
   logic         req_taken = 1'b0;
   int unsigned  gap_left = 0;
   int unsigned  burst_left = 0;
   int unsigned  idle_cycles = 0;

   // Shadow allocator state
   logic [63:0]  shadow_bitmap [NUM_WORDS];
   int unsigned  shadow_search;
   int unsigned  shadow_free;
   sbma_rsp_type expected_rsps[$];
   int unsigned  granted_pool[$];

   // Run statistics
   int unsigned  mismatch_count = 0;
   int unsigned  results_checked = 0;
   int unsigned  grant_count = 0;
   int unsigned  refusal_count = 0;
   int unsigned  freed_count = 0;
   int unsigned  unused_count = 0;
   int unsigned  skipped_words = 0;

   swap_slot_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_bus),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void reset_shadow();
      foreach (shadow_bitmap[w]) shadow_bitmap[w] = '0;
      shadow_bitmap[0] = 64'd1;   // slot 0 reserved for good
      shadow_search = 0;
      shadow_free = TOTAL_SLOTS - 1;
   endfunction

   // Work out the results of one accepted request and update the shadow state
   function automatic void predict_request(sbma_req_type r);
      int unsigned  word_idx;
      int unsigned  bit_idx;
      int unsigned  scanned;
      sbma_rsp_type res;
      sbma_rsp_type run[$];
      res = '0;
      res.last_of_run = 1'b1;
      if (r.action == ACTION_FREE) begin
         word_idx = r.slot_to_release / WORD_BITS;
         bit_idx = r.slot_to_release % WORD_BITS;
         res.slot_number = r.slot_to_release;
         if (r.slot_to_release == 0 || !shadow_bitmap[word_idx][bit_idx]) begin
            res.status = STATUS_UNUSED;
            unused_count++;
         end else begin
            shadow_bitmap[word_idx][bit_idx] = 1'b0;
            shadow_free++;
            res.status = STATUS_FREED;
            freed_count++;
         end
         res.slots_free = 12'(shadow_free);
         expected_rsps.push_back(res);
         return;
      end
      if (r.request_count == 0 || r.request_count > MAX_COUNT ||
          shadow_free < r.request_count) begin
         res.status = STATUS_REFUSED;
         res.slots_free = 12'(shadow_free);
         expected_rsps.push_back(res);
         refusal_count++;
         return;
      end
      // Next fit: full words are passed over, the pointer stays on the hit word
      for (int i = 0; i < r.request_count; i++) begin
         scanned = 0;
         while (shadow_bitmap[shadow_search] == '1 && scanned < NUM_WORDS) begin
            shadow_search = (shadow_search + 1) % NUM_WORDS;
            scanned++;
            skipped_words++;
         end
         if (shadow_bitmap[shadow_search] == '1) break;
         bit_idx = 0;
         while (bit_idx < 63 && shadow_bitmap[shadow_search][bit_idx]) bit_idx++;
         shadow_bitmap[shadow_search][bit_idx] = 1'b1;
         shadow_free--;
         res.slot_number = 12'(shadow_search * WORD_BITS + bit_idx);
         res.status = STATUS_GRANTED;
         res.last_of_run = 1'b0;
         res.slots_free = 12'(shadow_free);
         run.push_back(res);
         granted_pool.push_back(res.slot_number);
         grant_count++;
      end
      if (run.size() == 0) begin
         res = '0;
         res.status = STATUS_REFUSED;
         res.last_of_run = 1'b1;
         res.slots_free = 12'(shadow_free);
         run.push_back(res);
         refusal_count++;
      end
      run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[k]) expected_rsps.push_back(run[k]);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic check_result(sbma_rsp_type got);
      sbma_rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch("result with none pending, slot", got.slot_number, 0);
         return;
      end
      want = expected_rsps.pop_front();
      results_checked++;
      if (got.slot_number !== want.slot_number)
         report_mismatch("slot_number", got.slot_number, want.slot_number);
      if (got.status !== want.status)
         report_mismatch("status", got.status, want.status);
      if (got.last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
      if (got.slots_free !== want.slots_free)
         report_mismatch("slots_free", got.slots_free, want.slots_free);
   endtask

   // Mostly short gaps, a few long ones, and stretches of back-to-back requests
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Driver: new request values go out on the falling edge
   always @(negedge clock) begin
      logic         next_start;
      sbma_req_type next_req;
      next_start = start;
      next_req = req_bus;
      if (reset) begin
         next_start = 1'b0;
      end else if (!start || req_taken) begin
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0 &&
                      (!pending_drain[0] || (expected_rsps.size() == 0 && !busy))) begin
            next_req = pending_reqs.pop_front();
            void'(pending_drain.pop_front());
            next_start = 1'b1;
            gap_left = pick_gap();
         end
      end
      start <= next_start;
      req_bus <= next_req;
   end

   // Monitor and watchdog: sample on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe === 1'b1) check_result(rsp);
         if (start && busy === 1'b0) predict_request(req_bus);
         req_taken <= start && busy === 1'b0;
         if ((start && busy === 1'b0) || rsp_strobe === 1'b1) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d cycles with no request or result", idle_cycles);
            $display("FAILED: results differ");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic queue_alloc(int unsigned count, bit drain_first = 1'b0);
      sbma_req_type r;
      while (pending_reqs.size() > 4) @(posedge clock);
      r = '0;
      r.action = ACTION_ALLOC;
      r.request_count = 5'(count);
      r.slot_to_release = 12'($urandom_range(0, TOTAL_SLOTS - 1));
      pending_reqs.push_back(r);
      pending_drain.push_back(drain_first);
   endtask

   task automatic queue_free(int unsigned slot, bit drain_first = 1'b0);
      sbma_req_type r;
      while (pending_reqs.size() > 4) @(posedge clock);
      r = '0;
      r.action = ACTION_FREE;
      r.request_count = 5'($urandom_range(0, 31));
      r.slot_to_release = 12'(slot);
      pending_reqs.push_back(r);
      pending_drain.push_back(drain_first);
   endtask

   // Free a slot that an accepted allocation handed out
   task automatic queue_pool_free();
      int unsigned idx;
      int unsigned slot;
      idx = $urandom_range(0, granted_pool.size() - 1);
      slot = granted_pool[idx];
      granted_pool.delete(idx);
      queue_free(slot);
   endtask

   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned pick;
      reset_shadow();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: count limits, reserved slot, double free, field bit patterns
      queue_alloc(1);
      queue_alloc(MAX_COUNT);
      queue_alloc(0);
      queue_alloc(MAX_COUNT + 1);
      queue_alloc(31);
      queue_free(0);
      queue_free(TOTAL_SLOTS - 1);
      queue_free(1);
      queue_free(1);
      queue_alloc(1);
      queue_free(12'hAAA);
      queue_free(12'h555);
      queue_alloc(2, 1'b1);
      queue_free(17);
      queue_alloc(3);

      // Random mix of allocations and frees, with some out-of-range noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (n == RANDOM_ITEMS / 2)
            queue_alloc($urandom_range(1, MAX_COUNT), 1'b1);
         else if (pick < 5)
            queue_alloc($urandom_range(0, 31));
         else if (pick < 10)
            queue_free($urandom_range(0, TOTAL_SLOTS - 1));
         else if (pick < 45 && granted_pool.size() > 0)
            queue_pool_free();
         else
            queue_alloc($urandom_range(1, MAX_COUNT));
      end

      // Small allocations mixed with frees of granted slots
      for (int n = 0; n < 60; n++) begin
         if ($urandom_range(0, 1) == 0 && granted_pool.size() > 0)
            queue_pool_free();
         else
            queue_alloc($urandom_range(1, 4));
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("checked %0d results: %0d grants, %0d refusals, %0d frees, %0d bad frees",
               results_checked, grant_count, refusal_count, freed_count, unused_count);
      $display("next-fit search passed over %0d full words", skipped_words);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/sbma_pkg.sv
src/sbma_bitmap_ram.sv
src/sbma_bit_unit.sv
src/swap_slot_bitmap_allocator.sv
bench/swap_slot_bitmap_allocator_tb.sv
